// ===== hw/rtl/fcf_pkg.sv =====
// package: sizes, types and helpers for the fundamental cycle finder
package fcf_pkg;
  localparam int MaxV = 16;
  localparam int VW = $clog2(MaxV);
  localparam int CW = VW + 1;
  localparam int PW = 2 * VW;
  localparam logic [PW-1:0] ScanEnd = {PW{1'b1}};
  localparam logic [CW-1:0] CfgReset = CW'(10);

  typedef logic [VW-1:0] vtx_t;
  typedef logic [MaxV-1:0] row_t;

  typedef struct packed {
    logic       mode;
    vtx_t       row_index;
    row_t       row_bits;
  } in_word_t;

  typedef struct packed {
    vtx_t vertex;
    logic last;
    logic status;
  } out_word_t;

  function automatic logic [CW-1:0] clamp_n(input logic [CW-1:0] v);
    logic [CW-1:0] r;
    r = v;
    if (v == '0) r = CW'(1);
    if (v > CW'(MaxV)) r = CW'(MaxV);
    return r;
  endfunction
endpackage

// ===== hw/rtl/fcf_if.sv =====
// valid/ready channel interfaces
interface fcf_in_if import fcf_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  in_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface fcf_out_if import fcf_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface fcf_cfg_if import fcf_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  logic [CW-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/fcf_seq.sv =====
// sequencer: tree build, edge scan, path search and result emission
module fcf_seq import fcf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  fcf_in_if.sink   in_ch,
  fcf_out_if.source out_ch,
  fcf_cfg_if.sink  cfg_ch
);
  typedef enum logic [2:0] {
    S_IDLE, S_BUILD, S_SCAN, S_PATH, S_EMIT, S_DONE
  } state_t;

  state_t state_r;
  row_t adj_r [MaxV];
  row_t tree_r [MaxV];
  logic [MaxV-1:0] vis_r;
  vtx_t pstk_r [MaxV];
  logic [CW-1:0] sstk_r [MaxV];
  logic [CW-1:0] plen_r;
  logic built_r;
  logic [PW-1:0] pos_r;
  logic [CW-1:0] nv_r;
  vtx_t tgt_r;
  logic [CW-1:0] emit_r;
  logic ovalid_r;
  out_word_t odata_r;

  logic [CW-1:0] n_act;
  vtx_t top_v;
  logic [CW-1:0] top_s;
  row_t cand;
  logic hit;
  vtx_t hit_v;
  vtx_t si, sj;
  logic cfg_go, in_go;

  assign n_act = clamp_n(nv_r);
  assign top_v = pstk_r[VW'(plen_r - CW'(1))];
  assign top_s = sstk_r[VW'(plen_r - CW'(1))];
  assign si = pos_r[PW-1:VW];
  assign sj = pos_r[VW-1:0];

  // candidate neighbors at or above the scan pointer, below n, unvisited
  always_comb begin
    cand = '0;
    for (int c = 0; c < MaxV; c++) begin
      if (CW'(c) >= top_s && CW'(c) < n_act && !vis_r[c]) begin
        if (state_r == S_BUILD) cand[c] = adj_r[top_v][c] | tree_r[top_v][c];
        else cand[c] = tree_r[top_v][c];
      end
    end
  end

  // priority encoder, lowest index first
  always_comb begin
    hit = 1'b0;
    hit_v = '0;
    for (int c = MaxV - 1; c >= 0; c--) begin
      if (cand[c]) begin
        hit = 1'b1;
        hit_v = VW'(c);
      end
    end
  end

  assign in_ch.ready = (state_r == S_IDLE) && !ovalid_r;
  assign cfg_ch.ready = (state_r == S_IDLE) && !ovalid_r;
  assign in_go = in_ch.valid && in_ch.ready;
  assign cfg_go = cfg_ch.valid && cfg_ch.ready;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data = odata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int r = 0; r < MaxV; r++) begin
        adj_r[r] <= '0;
        tree_r[r] <= '0;
      end
      vis_r <= '0;
      plen_r <= '0;
      built_r <= 1'b0;
      pos_r <= '0;
      nv_r <= CfgReset;
      ovalid_r <= 1'b0;
      emit_r <= '0;
    end else begin
      if (ovalid_r && out_ch.ready && state_r != S_EMIT && state_r != S_DONE) begin
        ovalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cfg_go) begin
            nv_r <= cfg_ch.data;
            for (int r = 0; r < MaxV; r++) tree_r[r] <= '0;
            built_r <= 1'b0;
            pos_r <= '0;
          end else if (in_go) begin
            if (!in_ch.data.mode) begin
              adj_r[in_ch.data.row_index] <= in_ch.data.row_bits;
              for (int r = 0; r < MaxV; r++) tree_r[r] <= '0;
              built_r <= 1'b0;
              pos_r <= '0;
            end else if (!built_r) begin
              vis_r <= MaxV'(1);
              pstk_r[0] <= '0;
              sstk_r[0] <= '0;
              plen_r <= CW'(1);
              state_r <= S_BUILD;
            end else begin
              state_r <= (pos_r == ScanEnd) ? S_DONE : S_SCAN;
            end
          end
        end
        S_BUILD: begin
          if (plen_r == '0) begin
            built_r <= 1'b1;
            state_r <= (pos_r == ScanEnd) ? S_DONE : S_SCAN;
          end else if (hit) begin
            sstk_r[VW'(plen_r - CW'(1))] <= {1'b0, hit_v} + CW'(1);
            tree_r[top_v][hit_v] <= 1'b1;
            tree_r[hit_v][top_v] <= 1'b1;
            vis_r[hit_v] <= 1'b1;
            if (plen_r < CW'(MaxV)) begin
              pstk_r[VW'(plen_r)] <= hit_v;
              sstk_r[VW'(plen_r)] <= '0;
              plen_r <= plen_r + CW'(1);
            end
          end else begin
            plen_r <= plen_r - CW'(1);
          end
        end
        S_SCAN: begin
          if (si < sj && {1'b0, sj} < n_act && adj_r[si][sj] && !tree_r[si][sj]) begin
            vis_r <= MaxV'(1) << si;
            pstk_r[0] <= si;
            sstk_r[0] <= '0;
            plen_r <= CW'(1);
            tgt_r <= sj;
            state_r <= S_PATH;
          end else if (pos_r == ScanEnd - PW'(1)) begin
            pos_r <= ScanEnd;
            state_r <= S_DONE;
          end else begin
            pos_r <= pos_r + PW'(1);
          end
        end
        S_PATH: begin
          if (plen_r == '0) begin
            if (pos_r == ScanEnd - PW'(1)) begin
              pos_r <= ScanEnd;
              state_r <= S_DONE;
            end else begin
              pos_r <= pos_r + PW'(1);
              state_r <= S_SCAN;
            end
          end else if (top_v == tgt_r) begin
            pos_r <= pos_r + PW'(1);
            emit_r <= '0;
            state_r <= S_EMIT;
          end else if (hit && plen_r < CW'(MaxV)) begin
            sstk_r[VW'(plen_r - CW'(1))] <= {1'b0, hit_v} + CW'(1);
            vis_r[hit_v] <= 1'b1;
            pstk_r[VW'(plen_r)] <= hit_v;
            sstk_r[VW'(plen_r)] <= '0;
            plen_r <= plen_r + CW'(1);
          end else begin
            plen_r <= plen_r - CW'(1);
          end
        end
        S_EMIT: begin
          if (!ovalid_r || out_ch.ready) begin
            ovalid_r <= 1'b1;
            odata_r.vertex <= pstk_r[VW'(emit_r)];
            odata_r.last <= (emit_r + CW'(1) == plen_r);
            odata_r.status <= 1'b0;
            emit_r <= emit_r + CW'(1);
            if (emit_r + CW'(1) == plen_r) state_r <= S_IDLE;
          end
        end
        S_DONE: begin
          if (!ovalid_r || out_ch.ready) begin
            ovalid_r <= 1'b1;
            odata_r.vertex <= '0;
            odata_r.last <= 1'b1;
            odata_r.status <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/fundamental_cycle_finder_unit.sv =====
// top level of the fundamental cycle finder
// channels: in (mode, row_index, row_bits), out (vertex, last, status), cfg (num_vertices)
// a mode 0 word writes one adjacency row and gives no result
// a mode 1 word asks for the next fundamental cycle; the block is busy until
// the whole path has been handed out
// the first request after a write builds the depth-first tree, one stack step a
// cycle; the edge scan then tests one matrix position a cycle, and each path
// search takes one stack step a cycle; result vertices are handed out one a
// cycle while the receiver is ready
// a request with no edges left gives one word with last and status set
// reset clears the matrix, tree and scan position and sets num_vertices to 10
// when the receiver stalls the output register holds its word and the
// sequencer waits; no new input or cfg word is taken until it drains
module fundamental_cycle_finder_unit import fcf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  fcf_in_if.sink    in_ch,
  fcf_out_if.source out_ch,
  fcf_cfg_if.sink   cfg_ch
);
  fcf_seq u_seq (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );
endmodule

// ===== hw/rtl/fcf_checker.sv =====
// port-level checker for the fundamental cycle finder
module fcf_port_checker import fcf_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_word_t out_data,
  input logic cfg_ready
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out word dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while output pending");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.last && out_data.vertex == '0)
    else $error("bad done word");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready == in_ready) else $error("cfg and input readiness differ");
endmodule

bind fundamental_cycle_finder_unit fcf_port_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
  .cfg_ready(cfg_ch.ready)
);

// ===== dv/fcf_checker.sv =====
// checker: predicts the cycle finder's result words and compares them with the block's output
module fcf_checker import fcf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  fcf_in_if    in_ch,
  fcf_out_if   out_ch,
  fcf_cfg_if   cfg_ch,
  output int   errors,
  output int   pending,
  output int   words_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] AdjMark = 2'b01;
  localparam logic [1:0] TreeMark = 2'b10;

  logic [1:0]    marks [MaxV][MaxV];
  logic          seen [MaxV];
  vtx_t          path_v [MaxV];
  logic [CW-1:0] next_col [MaxV];
  int            depth;
  logic          tree_ok;
  logic [PW-1:0] scan_pos;
  logic [CW-1:0] nv_reg;
  out_word_t     cycle_words [$];

  function automatic int vertices_in_use();
    int n;
    n = nv_reg;
    if (n < 1) n = 1;
    if (n > MaxV) n = MaxV;
    return n;
  endfunction

  function automatic void drop_tree();
    for (int r = 0; r < MaxV; r++)
      for (int c = 0; c < MaxV; c++)
        marks[r][c] = marks[r][c] & AdjMark;
    tree_ok = 1'b0;
    scan_pos = '0;
  endfunction

  function automatic void grow_tree();
    int n, t, v, hit;
    n = vertices_in_use();
    for (int k = 0; k < MaxV; k++) seen[k] = 1'b0;
    path_v[0] = '0;
    next_col[0] = '0;
    seen[0] = 1'b1;
    depth = 1;
    while (depth > 0) begin
      t = depth - 1;
      v = path_v[t];
      hit = MaxV;
      for (int c = next_col[t]; c < n; c++)
        if (!seen[c] && marks[v][c] != 2'b00) begin
          hit = c;
          break;
        end
      if (hit < n) begin
        next_col[t] = CW'(hit + 1);
        marks[v][hit] = marks[v][hit] | TreeMark;
        marks[hit][v] = marks[hit][v] | TreeMark;
        seen[hit] = 1'b1;
        if (depth < MaxV) begin
          path_v[depth] = vtx_t'(hit);
          next_col[depth] = '0;
          depth++;
        end
      end else begin
        depth--;
      end
    end
    tree_ok = 1'b1;
  endfunction

  function automatic int tree_path(int a, int b);
    int n, t, v, hit;
    n = vertices_in_use();
    for (int k = 0; k < MaxV; k++) seen[k] = 1'b0;
    path_v[0] = vtx_t'(a);
    next_col[0] = '0;
    seen[a] = 1'b1;
    depth = 1;
    while (depth > 0) begin
      t = depth - 1;
      v = path_v[t];
      hit = MaxV;
      if (v == b) return depth;
      for (int c = next_col[t]; c < n; c++)
        if (!seen[c] && (marks[v][c] & TreeMark) != 2'b00) begin
          hit = c;
          break;
        end
      if (hit < n && depth < MaxV) begin
        next_col[t] = CW'(hit + 1);
        seen[hit] = 1'b1;
        path_v[depth] = vtx_t'(hit);
        next_col[depth] = '0;
        depth++;
      end else begin
        depth--;
      end
    end
    return 0;
  endfunction

  function automatic void predict_word(in_word_t w);
    int n, i, j, len;
    out_word_t o;
    n = vertices_in_use();
    if (w.mode == 1'b0) begin
      drop_tree();
      for (int k = 0; k < MaxV; k++)
        marks[w.row_index][k] = (marks[w.row_index][k] & TreeMark) | {1'b0, w.row_bits[k]};
      return;
    end
    if (!tree_ok) grow_tree();
    for (int p = scan_pos; p < int'(ScanEnd); p++) begin
      i = p >> VW;
      j = p & (MaxV - 1);
      if (i < j && j < n && marks[i][j] == AdjMark) begin
        len = tree_path(i, j);
        if (len > 0) begin
          scan_pos = PW'(p + 1);
          for (int k = 0; k < len; k++) begin
            o.vertex = path_v[k];
            o.last = (k + 1 == len);
            o.status = 1'b0;
            cycle_words.push_back(o);
          end
          return;
        end
      end
    end
    scan_pos = ScanEnd;
    o.vertex = '0;
    o.last = 1'b1;
    o.status = 1'b1;
    cycle_words.push_back(o);
  endfunction

  function automatic void flag_mismatch(string what, out_word_t exp_w, out_word_t got_w);
    if (errors < 10)
      $display("mismatch (%s): expected vertex %0d last %0b status %0b, got vertex %0d last %0b status %0b",
               what, exp_w.vertex, exp_w.last, exp_w.status, got_w.vertex, got_w.last,
               got_w.status);
    errors++;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    words_seen = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MaxV; r++)
        for (int c = 0; c < MaxV; c++)
          marks[r][c] = 2'b00;
      tree_ok = 1'b0;
      scan_pos = '0;
      depth = 0;
      nv_reg = CfgReset;
      cycle_words.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        nv_reg = cfg_ch.data;
        drop_tree();
      end
      if (in_ch.valid && in_ch.ready) predict_word(in_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        words_seen++;
        if (cycle_words.size() == 0) begin
          flag_mismatch("no word expected", '0, out_ch.data);
        end else begin
          out_word_t e;
          e = cycle_words.pop_front();
          if (e.vertex !== out_ch.data.vertex) flag_mismatch("vertex", e, out_ch.data);
          if (e.last !== out_ch.data.last) flag_mismatch("last", e, out_ch.data);
          if (e.status !== out_ch.data.status) flag_mismatch("status", e, out_ch.data);
        end
      end
    end
    pending = cycle_words.size();
  end
endmodule

// ===== dv/fundamental_cycle_finder_unit_tb.sv =====
// testbench top: stimulus, output stalls and verdict for the fundamental cycle finder
module fundamental_cycle_finder_unit_tb;
  import fcf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1500000;

  logic clk;
  logic rst_n;
  int   errors, pending, words_seen;
  int   item_count, graph_count, cycle_count;
  logic hold_out;
  row_t adj [MaxV];

  fcf_in_if  in_ch(clk);
  fcf_out_if out_ch(clk);
  fcf_cfg_if cfg_ch(clk);

  fundamental_cycle_finder_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  fcf_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .errors(errors), .pending(pending), .words_seen(words_seen)
  );

  always #2 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(logic mode, vtx_t row, row_t bits);
    int gap;
    in_ch.data.mode <= mode;
    in_ch.data.row_index <= row;
    in_ch.data.row_bits <= bits;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    item_count++;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_nv(logic [CW-1:0] nv);
    wait_idle();
    cfg_ch.data <= nv;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_graph(int n, int density, bit symmetric);
    for (int r = 0; r < MaxV; r++) adj[r] = '0;
    for (int r = 0; r < n; r++)
      for (int c = r + 1; c < n; c++)
        if ($urandom_range(0, 99) < density) begin
          adj[r][c] = 1'b1;
          adj[c][r] = 1'b1;
        end
    if (!symmetric)
      for (int r = 0; r < n; r++) adj[r] = adj[r] ^ row_t'($urandom());
  endtask

  task automatic run_graph(logic [CW-1:0] nv, int n, int density, bit symmetric, int asks);
    write_nv(nv);
    random_graph(n, density, symmetric);
    for (int r = 0; r < n; r++) send_word(1'b0, vtx_t'(r), adj[r]);
    for (int q = 0; q < asks; q++) begin
      if ($urandom_range(0, 99) < 8)
        send_word(1'b0, vtx_t'($urandom_range(0, MaxV - 1)), row_t'($urandom()));
      send_word(1'b1, vtx_t'($urandom()), row_t'($urandom()));
    end
    graph_count++;
  endtask

  initial begin
    hold_out = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 60)) @(posedge clk);
        if ($urandom_range(0, 3) != 0) begin
          out_ch.ready <= 1'b0;
          repeat (pick_gap() + 1) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int n, nv, pick;
    clk = 1'b0;
    rst_n = 1'b0;
    cycle_count = 0;
    item_count = 0;
    graph_count = 0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty matrix at reset size, then a triangle
    send_word(1'b1, '0, '0);
    send_word(1'b1, '1, '1);
    write_nv(CW'(3));
    send_word(1'b0, 4'd0, 16'h0006);
    send_word(1'b0, 4'd1, 16'h0005);
    send_word(1'b0, 4'd2, 16'h0003);
    send_word(1'b1, '0, '0);
    send_word(1'b1, '0, '0);
    send_word(1'b1, '0, '0);
    // zero size acts as one vertex
    write_nv(CW'(0));
    send_word(1'b1, '0, '0);
    // full graph at the largest clamped size, self loops included
    write_nv(CW'(31));
    for (int r = 0; r < MaxV; r++) send_word(1'b0, vtx_t'(r), 16'hffff);
    send_word(1'b1, '0, '0);
    send_word(1'b1, '0, '0);
    // edge away from vertex 0 has no tree path, one-way edge
    write_nv(CW'(4));
    for (int r = 0; r < MaxV; r++) send_word(1'b0, vtx_t'(r), 16'h0000);
    send_word(1'b0, 4'd2, 16'h0008);
    send_word(1'b0, 4'd3, 16'h0004);
    send_word(1'b0, 4'd0, 16'h0002);
    send_word(1'b1, '0, '0);
    send_word(1'b1, '0, '0);
    write_nv(CW'(16));
    send_word(1'b1, '0, '0);
    write_nv(CW'(1));
    send_word(1'b1, '0, '0);

    while (item_count < 170) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        n = $urandom_range(3, 7);
        nv = n;
      end else if (pick < 80) begin
        n = MaxV;
        nv = MaxV;
      end else if (pick < 90) begin
        n = MaxV;
        nv = $urandom_range(17, 31);
      end else begin
        n = $urandom_range(2, 9);
        nv = $urandom_range(0, 16);
      end
      if (graph_count == 3) hold_out = 1'b1;
      run_graph(CW'(nv), n, $urandom_range(20, 90), $urandom_range(0, 9) == 0,
                $urandom_range(2, 10));
      if ($urandom_range(0, 4) == 0) wait_idle();
    end

    wait_idle();
    repeat (600) @(posedge clk);
    $display("sent %0d input words over %0d random graphs plus directed cases", item_count,
             graph_count);
    $display("checked %0d result words", words_seen);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
